// ===== design/line_sensor_crossing_reading_unit_macros.svh =====
// Assertion helpers for the line sensor crossing reading unit.
`ifndef LINE_SENSOR_CROSSING_READING_UNIT_MACROS_SVH
`define LINE_SENSOR_CROSSING_READING_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define LSCR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define LSCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lscr_pkg.sv =====
package lscr_pkg;

  localparam int MaxSegmentsDef = 64;
  localparam int CoordBitsDef   = 24;
  localparam int FracBitsDef    = 10;
  localparam int ReadBits       = 25;
  localparam int NoCrossValue   = 100;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL1,
    ST_MUL2,
    ST_CHK,
    ST_SQ,
    ST_SQRT,
    ST_NUM,
    ST_PROD,
    ST_PLO,
    ST_PHI,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== design/line_sensor_crossing_reading_unit.sv =====
// Line sensor crossing reading unit. An append transaction (kind 0) stores a
// track segment in the on-chip table at the accepting edge; busy stays low, the
// transaction is dropped when the table is full and it returns nothing. A query
// transaction (kind 1) walks the stored segments one by one (memory read,
// multiply states MUL1 and MUL2, compare), then, if a crossing was found, runs a
// bit-serial square root (one result bit per cycle, C+2 steps), a split multiply
// (low and high halves) and a restoring divider (one quotient bit per cycle, 3*C+6
// steps), C the coordinate width. busy is high from the accepting edge until the
// query is done. The single result shows on reading/crossed for one cycle with
// valid high, in the first cycle with busy low again; the receiver cannot stall
// it, so it must take it in that cycle.
`include "line_sensor_crossing_reading_unit_macros.svh"

module line_sensor_crossing_reading_unit
  import lscr_pkg::*;
#(
  parameter int MAX_SEGMENTS = MaxSegmentsDef,
  parameter int COORD_BITS   = CoordBitsDef,
  parameter int FRAC_BITS    = FracBitsDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         valid,
  output logic signed [ReadBits-1:0]   reading,
  output logic                         crossed
);

  localparam int AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW  = $clog2(MAX_SEGMENTS + 1);
  localparam int DW  = COORD_BITS + 1;        // differences
  localparam int PW  = 2 * DW;                // products
  localparam int SW  = PW + 1;                // cross terms
  localparam int LW  = DW + 1;                // sqrt result bits
  localparam int NW  = SW + 1;                // D - 2T
  localparam int HW  = NW / 2;                // half of D - 2T for the split multiply
  localparam int QW  = NW + LW;               // dividend width
  localparam int QCW = $clog2(QW + 1);
  localparam int LCW = $clog2(LW + 1);
  localparam logic signed [ReadBits-1:0] ReadMax = {1'b0, {(ReadBits-1){1'b1}}};
  localparam logic signed [ReadBits-1:0] ReadMin = {1'b1, {(ReadBits-1){1'b0}}};
  localparam longint NoCrossRaw = longint'(NoCrossValue) <<< FRAC_BITS;
  localparam logic signed [ReadBits-1:0] NoCross =
    (NoCrossRaw > longint'(ReadMax)) ? ReadMax : ReadBits'(NoCrossRaw);

  // Segment table: one memory, four coordinates per entry.
  logic [4*COORD_BITS-1:0] mem [MAX_SEGMENTS];
  logic [4*COORD_BITS-1:0] rd_data;
  logic [4*COORD_BITS-1:0] wr_data;
  logic                    wr_en;
  logic [AW-1:0]           rd_addr;

  state_t state, state_next;

  logic [CW-1:0] seg_count, idx;
  logic signed [COORD_BITS-1:0] qsx, qsy;
  logic signed [DW-1:0] s1x, s1y;
  logic signed [DW-1:0] s2x, s2y, dx, dy;
  logic signed [PW-1:0] p0, p1;
  logic signed [SW-1:0] dd, ss, tt;
  logic found;
  logic signed [SW-1:0] best_d, best_t;
  logic [SW-1:0] sq;
  logic [LW-1:0] root;
  logic [LCW-1:0] bitc;
  logic neg;
  logic [NW-1:0] nmag;
  logic [HW+LW-1:0] plo, phi;
  logic [QW-1:0] dividend;
  logic [QW:0]   rem;
  logic [QW-1:0] quo;
  logic [QCW-1:0] qcnt;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[seg_count[AW-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign wr_data = {start_x, start_y, end_x, end_y};
  assign wr_en   = start && !busy && (kind == KIND_APPEND) &&
                   (seg_count < CW'(MAX_SEGMENTS));
  assign rd_addr = idx[AW-1:0];

  logic signed [COORD_BITS-1:0] m_sx, m_sy, m_ex, m_ey;
  assign {m_sx, m_sy, m_ex, m_ey} = rd_data;

  // Cross terms after negation so D is positive.
  logic signed [SW-1:0] dn, sn, tn;
  assign dn = dd[SW-1] ? -dd : dd;
  assign sn = dd[SW-1] ? -ss : ss;
  assign tn = dd[SW-1] ? -tt : tt;
  logic hit;
  assign hit = (dd != '0) && !sn[SW-1] && (sn <= dn) && !tn[SW-1] && (tn <= dn);

  // Square root trial.
  logic [LW-1:0] rtry;
  logic [2*LW-1:0] rsq;
  assign rtry = root | (LW'(1) << bitc);
  assign rsq  = rtry * rtry;

  // Upper half product of |D - 2T| times the length.
  assign phi = nmag[NW-1:HW] * root;

  // Divider step.
  logic [QW:0] rsh;
  logic [QW:0] den2;
  assign rsh  = {rem[QW-1:0], dividend[QW-1]};
  assign den2 = (QW+1)'({best_d, 1'b0});

  logic [QW-1:0] qsat;
  assign qsat = quo;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start && kind == KIND_QUERY) state_next = ST_RD;
      ST_RD:   state_next = (idx < seg_count) ? ST_MUL1 : (found ? ST_SQ : ST_OUT);
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_CHK;
      ST_CHK:  state_next = ST_RD;
      ST_SQ:   state_next = ST_SQRT;
      ST_SQRT: if (bitc == '0) state_next = ST_NUM;
      ST_NUM:  state_next = ST_PROD;
      ST_PROD: state_next = ST_PLO;
      ST_PLO:  state_next = ST_PHI;
      ST_PHI:  state_next = ST_DIV;
      ST_DIV:  if (qcnt == QCW'(1)) state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg_count <= '0;
      valid     <= 1'b0;
    end else begin
      state <= state_next;
      valid <= (state == ST_OUT);
      if (wr_en) seg_count <= seg_count + CW'(1);
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        qsx   <= start_x;
        qsy   <= start_y;
        s1x   <= DW'(end_x) - DW'(start_x);
        s1y   <= DW'(end_y) - DW'(start_y);
        idx   <= '0;
        found <= 1'b0;
      end
      ST_RD: begin
        idx <= idx + CW'(1);
      end
      ST_MUL1: begin
        s2x <= DW'(m_ex) - DW'(m_sx);
        s2y <= DW'(m_ey) - DW'(m_sy);
        dx  <= DW'(qsx) - DW'(m_sx);
        dy  <= DW'(qsy) - DW'(m_sy);
      end
      ST_MUL2: begin
        dd <= SW'(s1x * s2y) - SW'(s2x * s1y);
        ss <= SW'(s1x * dy) - SW'(s1y * dx);
        tt <= SW'(s2x * dy) - SW'(s2y * dx);
      end
      ST_CHK: begin
        if (hit) begin
          found  <= 1'b1;
          best_d <= dn;
          best_t <= tn;
        end
      end
      ST_SQ: begin
        sq   <= SW'(s1x * s1x) + SW'(s1y * s1y);
        root <= '0;
        bitc <= LCW'(LW - 1);
      end
      ST_SQRT: begin
        if ({{(2*LW-SW){1'b0}}, sq} >= rsq) root <= rtry;
        bitc <= bitc - LCW'(1);
      end
      ST_NUM: begin
        nmag <= NW'(best_d) - (NW'(best_t) <<< 1);
      end
      ST_PROD: begin
        neg  <= nmag[NW-1];
        nmag <= nmag[NW-1] ? -nmag : nmag;
      end
      ST_PLO: begin
        plo <= nmag[HW-1:0] * root;
      end
      ST_PHI: begin
        dividend <= (QW'(phi) << HW) + QW'(plo) + QW'(best_d);
        rem      <= '0;
        quo      <= '0;
        qcnt     <= QCW'(QW);
      end
      ST_DIV: begin
        dividend <= dividend << 1;
        if (rsh >= den2) begin
          rem <= rsh - den2;
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= rsh;
          quo <= {quo[QW-2:0], 1'b0};
        end
        qcnt <= qcnt - QCW'(1);
      end
      ST_OUT: begin
        crossed <= found;
        if (!found) begin
          reading <= NoCross;
        end else if (neg) begin
          reading <= (qsat > QW'(ReadMax) + QW'(1)) ? ReadMin : ReadBits'(-qsat);
        end else begin
          reading <= (qsat > QW'(ReadMax)) ? ReadMax : ReadBits'(qsat);
        end
      end
      default: ;
    endcase
  end

  `LSCR_ASSERT_IMPL(a_count_bound, 1'b1, seg_count <= CW'(MAX_SEGMENTS), "count over size")
  `LSCR_ASSERT_NEXT(a_valid_after_out, state == ST_OUT, valid, "result missing")
  `LSCR_ASSERT_IMPL(a_no_write_busy, wr_en, !busy, "write while busy")
  `LSCR_ASSERT_IMPL(a_walk_bound, state == ST_MUL1, idx <= seg_count, "walk past table")

endmodule
